/* rtl/multilevel_feedback_scheduler_assert.svh */
// ----------------------------------------------------------------------------
// Multilevel feedback scheduler assertion macros
// Concurrent assertion wrappers, removed when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked at every rising edge outside reset.
`define MFS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define MFS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define MFS_ASSERT(label, clk, rst, prop, msg)

`define MFS_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

/* rtl/mfs_pkg.sv */
// ----------------------------------------------------------------------------
// mfs_pkg
// Types and constants shared by the multilevel feedback scheduler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mfs_pkg;

  localparam int DEF_MAX_THREADS = 16;
  localparam int DEF_NUM_LEVELS  = 5;

  localparam int REQ_TYPE_W = 3;
  localparam int TID_W      = 4;

  // Depth of the command queue between the front and back parts.
  localparam int CMDQ_DEPTH = 2;

  // Event codes carried in req_type.
  localparam logic [REQ_TYPE_W-1:0] EV_NEW     = 3'd0;
  localparam logic [REQ_TYPE_W-1:0] EV_BLOCK   = 3'd1;
  localparam logic [REQ_TYPE_W-1:0] EV_END     = 3'd2;
  localparam logic [REQ_TYPE_W-1:0] EV_UNBLOCK = 3'd3;
  localparam logic [REQ_TYPE_W-1:0] EV_TIMER   = 3'd4;

  typedef struct packed {
    logic [REQ_TYPE_W-1:0] req_type;
    logic [TID_W-1:0]      thread_id;
  } req_t;

  typedef struct packed {
    logic             switched;
    logic [TID_W-1:0] old_thread;
    logic [TID_W-1:0] next_thread;
    logic             idle;
  } rsp_t;

  // Classified operation handed from the front part to the back part.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_NEW,
    OP_UNBLOCK,
    OP_TIMER,
    OP_DISPATCH
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t          op;
    logic [TID_W-1:0] tid;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH,
    ST_POP_RD,
    ST_POP
  } back_state_t;

endpackage

`default_nettype wire

/* rtl/mfs_front.sv */
// ----------------------------------------------------------------------------
// mfs_front
// Accepts scheduler events and classifies them into back-end operations.
// ----------------------------------------------------------------------------
`default_nettype none

module mfs_front
  import mfs_pkg::*;
#(
  parameter int MAX_THREADS = DEF_MAX_THREADS
) (
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      cmd_valid,
  input  wire logic cmd_ready,
  output cmd_t      cmd
);

  logic in_range;

  assign in_range  = 32'(req.thread_id) < MAX_THREADS;
  assign cmd_valid = req_valid;
  assign req_ready = cmd_ready;

  // Unknown events and threads beyond the table become no-operations that
  // still produce an all-zero result.
  always_comb begin
    cmd.tid = req.thread_id;
    cmd.op  = OP_NOP;
    if (in_range) begin
      unique case (req.req_type)
        EV_NEW:            cmd.op = OP_NEW;
        EV_BLOCK, EV_END:  cmd.op = OP_DISPATCH;
        EV_UNBLOCK:        cmd.op = OP_UNBLOCK;
        EV_TIMER:          cmd.op = OP_TIMER;
        default:           cmd.op = OP_NOP;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/mfs_cmd_queue.sv */
// ----------------------------------------------------------------------------
// mfs_cmd_queue
// Short FIFO of classified operations between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module mfs_cmd_queue
  import mfs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire cmd_t push_cmd,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output cmd_t      pop_cmd
);

  localparam int PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  cmd_t             slots [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != CNT_W'(CMDQ_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/mfs_back.sv */
// ----------------------------------------------------------------------------
// mfs_back
// Executes queued operations on the ready queues and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multilevel_feedback_scheduler_assert.svh"

module mfs_back
  import mfs_pkg::*;
#(
  parameter int MAX_THREADS = DEF_MAX_THREADS,
  parameter int NUM_LEVELS  = DEF_NUM_LEVELS
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_ready,
  input  wire cmd_t cmd_in,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  localparam int TIDX_W = $clog2(MAX_THREADS);
  localparam int LVL_W  = $clog2(NUM_LEVELS);
  localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(NUM_LEVELS - 1);

  back_state_t state;
  back_state_t state_next;

  cmd_t cmd_q;

  // Per-thread tables, undefined until written.
  logic [LVL_W-1:0] lvl_mem  [MAX_THREADS];
  logic [TID_W-1:0] link_mem [MAX_THREADS];
  logic [LVL_W-1:0] lvl_rd;
  logic [TID_W-1:0] link_rd;

  logic [TID_W-1:0]      head [NUM_LEVELS];
  logic [TID_W-1:0]      tail [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] nonempty;
  logic [TID_W-1:0]      running;
  logic [LVL_W-1:0]      pop_lvl;

  logic             slot_free;
  logic             cmd_pop;
  logic [LVL_W-1:0] lvl_demoted;
  logic [LVL_W-1:0] lvl_clamped;
  logic [LVL_W-1:0] push_lvl;
  logic [LVL_W-1:0] lvl_sel;
  logic [TID_W-1:0] head_sel;
  logic [TID_W-1:0] tail_sel;
  logic             any_ready;
  logic [LVL_W-1:0] first_lvl;
  logic             lvl_we;
  logic             link_we;
  logic             rsp_load;
  rsp_t             rsp_next;

  assign slot_free = !rsp_valid || rsp_ready;
  assign cmd_pop   = cmd_valid && cmd_ready;
  assign head_sel  = head[lvl_sel];
  assign tail_sel  = tail[lvl_sel];

  // Level arithmetic on the remembered level read for the current thread.
  always_comb begin
    if (32'(lvl_rd) + 1 < NUM_LEVELS) begin
      lvl_demoted = lvl_rd + LVL_W'(1);
    end else begin
      lvl_demoted = LVL_LAST;
    end
    if (32'(lvl_rd) >= NUM_LEVELS) begin
      lvl_clamped = LVL_LAST;
    end else begin
      lvl_clamped = lvl_rd;
    end
    unique case (cmd_q.op)
      OP_NEW:   push_lvl = '0;
      OP_TIMER: push_lvl = lvl_demoted;
      default:  push_lvl = lvl_clamped;
    endcase
  end

  // Highest-priority non-empty level.
  always_comb begin
    any_ready = 1'b0;
    first_lvl = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        any_ready = 1'b1;
        first_lvl = LVL_W'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_pop) begin
          unique case (cmd_in.op)
            OP_NOP:      state_next = ST_IDLE;
            OP_DISPATCH: state_next = ST_POP_RD;
            default:     state_next = ST_PUSH;
          endcase
        end
      end
      ST_PUSH:   state_next = (cmd_q.op == OP_TIMER) ? ST_POP_RD : ST_IDLE;
      ST_POP_RD: state_next = any_ready ? ST_POP : ST_IDLE;
      ST_POP:    state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready = 1'b0;
    rsp_load  = 1'b0;
    rsp_next  = '0;
    lvl_we    = 1'b0;
    link_we   = 1'b0;
    lvl_sel   = push_lvl;
    unique case (state)
      ST_IDLE: begin
        cmd_ready = slot_free;
        rsp_load  = cmd_valid && slot_free && (cmd_in.op == OP_NOP);
      end
      ST_PUSH: begin
        lvl_sel  = push_lvl;
        lvl_we   = (cmd_q.op == OP_NEW) || (cmd_q.op == OP_TIMER);
        link_we  = nonempty[push_lvl];
        rsp_load = cmd_q.op != OP_TIMER;
      end
      ST_POP_RD: begin
        lvl_sel = first_lvl;
        if (!any_ready) begin
          rsp_load            = 1'b1;
          rsp_next.switched   = 1'b1;
          rsp_next.old_thread = running;
          rsp_next.idle       = 1'b1;
        end
      end
      ST_POP: begin
        lvl_sel              = pop_lvl;
        rsp_load             = 1'b1;
        rsp_next.switched    = 1'b1;
        rsp_next.old_thread  = running;
        rsp_next.next_thread = head_sel;
      end
      default: begin
        lvl_sel = push_lvl;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_q <= cmd_in;
    end
    if (state == ST_POP_RD) begin
      pop_lvl <= first_lvl;
    end
  end

  always_ff @(posedge clk) begin
    if (lvl_we) begin
      lvl_mem[TIDX_W'(cmd_q.tid)] <= push_lvl;
    end
    lvl_rd <= lvl_mem[TIDX_W'(cmd_in.tid)];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[TIDX_W'(tail_sel)] <= cmd_q.tid;
    end
    link_rd <= link_mem[TIDX_W'(head_sel)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
      end
      nonempty <= '0;
      running  <= '0;
    end else if (state == ST_PUSH) begin
      tail[push_lvl] <= cmd_q.tid;
      if (!nonempty[push_lvl]) begin
        head[push_lvl]     <= cmd_q.tid;
        nonempty[push_lvl] <= 1'b1;
      end
    end else if (state == ST_POP) begin
      running <= head_sel;
      if (head_sel == tail_sel) begin
        nonempty[pop_lvl] <= 1'b0;
      end else begin
        head[pop_lvl] <= link_rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  `MFS_ASSERT(a_rsp_no_overwrite, clk, rst, rsp_load |-> slot_free, "result overwritten")
  `MFS_ASSERT(a_pop_level_ready, clk, rst, (state == ST_POP) |-> nonempty[pop_lvl], "pop from empty level")
  `MFS_ASSERT(a_idle_all_empty, clk, rst, (rsp_load && rsp_next.idle) |-> (nonempty == '0), "idle with ready thread")
  `MFS_ASSERT(a_timer_dispatches, clk, rst, (state == ST_PUSH && cmd_q.op == OP_TIMER) |=> (state == ST_POP_RD), "timer without dispatch")
  `MFS_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (state == ST_IDLE && !rsp_valid), "not idle after reset")

endmodule

`default_nettype wire

/* rtl/multilevel_feedback_scheduler.sv */
// An event (new, block, end, unblock, timer expiry) names a thread; every accepted event
// yields exactly one result transaction. The back end enqueues for new, unblock and timer,
// and dequeues for block, end and timer (after the enqueue), reading the queue head first;
// its steps follow from the registered read ports of the per-thread level and link tables,
// which the enqueue and dequeue read-modify-writes pass through. The result becomes
// visible the cycle after the back end finishes, and a two-entry command queue lets the
// front keep taking events while the back end works or a result waits to be taken.
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler
// Multilevel feedback queue thread scheduler with a decoupled front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module multilevel_feedback_scheduler
  import mfs_pkg::*;
#(
  parameter int MAX_THREADS = DEF_MAX_THREADS,
  parameter int NUM_LEVELS  = DEF_NUM_LEVELS
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  // Ready threads wait in NUM_LEVELS FIFO queues kept as linked lists, level 0
  // having the highest priority. A new thread enters level 0, an unblock
  // re-queues the thread at its remembered level and a timer expiry demotes it
  // one level, saturating at the lowest. Block, end and timer transactions
  // dispatch the oldest thread of the highest non-empty level, or report idle
  // when every queue is empty. Out-of-range threads and unknown event codes
  // leave the state untouched and return an all-zero result.

  logic fe_valid;
  logic fe_ready;
  cmd_t fe_cmd;
  logic be_valid;
  logic be_ready;
  cmd_t be_cmd;

  // Front: accepts events and classifies them.
  mfs_front #(
    .MAX_THREADS(MAX_THREADS)
  ) u_front (
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .cmd_valid(fe_valid),
    .cmd_ready(fe_ready),
    .cmd      (fe_cmd)
  );

  // Decouples the two halves so that each may stall on its own.
  mfs_cmd_queue u_cmd_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(fe_valid),
    .push_ready(fe_ready),
    .push_cmd  (fe_cmd),
    .pop_valid (be_valid),
    .pop_ready (be_ready),
    .pop_cmd   (be_cmd)
  );

  // Back: walks the queue tables and holds the result until it is taken.
  mfs_back #(
    .MAX_THREADS(MAX_THREADS),
    .NUM_LEVELS (NUM_LEVELS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(be_valid),
    .cmd_ready(be_ready),
    .cmd_in   (be_cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire

/* tb/mfs_sched_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multilevel feedback scheduler checker
// Watches the event and decision channels, keeps its own copy of the ready
// queues and compares every decision transaction with the predicted one.
// ----------------------------------------------------------------------------

module mfs_sched_checker
  import mfs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  output int   mismatches,
  output int   outstanding,
  output int   decisions_seen,
  output int   dispatches_seen,
  output int   idles_seen
);

  localparam int LVL_W = 3;

  // Shadow scheduler state.
  logic [LVL_W-1:0] thread_lvl [DEF_MAX_THREADS];
  logic [TID_W-1:0] link_of    [DEF_MAX_THREADS];
  logic [TID_W-1:0] head_of    [DEF_NUM_LEVELS];
  logic [TID_W-1:0] tail_of    [DEF_NUM_LEVELS];
  logic             occupied   [DEF_NUM_LEVELS];
  logic [TID_W-1:0] running;

  // Decisions predicted but not yet seen on the output channel, oldest first.
  rsp_t awaited_decisions [$];

  initial begin
    mismatches      = 0;
    outstanding     = 0;
    decisions_seen  = 0;
    dispatches_seen = 0;
    idles_seen      = 0;
  end

  function automatic void clear_shadow();
    for (int i = 0; i < DEF_MAX_THREADS; i++) begin
      thread_lvl[i] = '0;
      link_of[i]    = '0;
    end
    for (int i = 0; i < DEF_NUM_LEVELS; i++) begin
      head_of[i]  = '0;
      tail_of[i]  = '0;
      occupied[i] = 1'b0;
    end
    running = '0;
  endfunction

  function automatic void enqueue(int lvl, logic [TID_W-1:0] tid);
    if (lvl >= DEF_NUM_LEVELS) begin
      lvl = DEF_NUM_LEVELS - 1;
    end
    if (occupied[lvl]) begin
      link_of[tail_of[lvl]] = tid;
      tail_of[lvl]          = tid;
    end else begin
      head_of[lvl]  = tid;
      tail_of[lvl]  = tid;
      occupied[lvl] = 1'b1;
    end
  endfunction

  function automatic logic [TID_W-1:0] dequeue(int lvl);
    logic [TID_W-1:0] tid;
    tid = head_of[lvl];
    if (tid == tail_of[lvl]) begin
      occupied[lvl] = 1'b0;
    end else begin
      head_of[lvl] = link_of[tid];
    end
    return tid;
  endfunction

  // Applies one event to the shadow queues and returns the decision it yields.
  function automatic rsp_t predict_dispatch(req_t ev);
    rsp_t             res;
    int               lvl;
    logic             do_dispatch;
    logic [TID_W-1:0] tid;
    res         = '0;
    do_dispatch = 1'b0;
    tid         = ev.thread_id;
    case (ev.req_type)
      EV_NEW: begin
        thread_lvl[tid] = '0;
        enqueue(0, tid);
      end
      EV_BLOCK, EV_END: begin
        do_dispatch = 1'b1;
      end
      EV_UNBLOCK: begin
        enqueue(int'(thread_lvl[tid]), tid);
      end
      EV_TIMER: begin
        lvl = int'(thread_lvl[tid]);
        if (lvl + 1 < DEF_NUM_LEVELS) begin
          lvl = lvl + 1;
        end else begin
          lvl = DEF_NUM_LEVELS - 1;
        end
        thread_lvl[tid] = LVL_W'(lvl);
        enqueue(lvl, tid);
        do_dispatch = 1'b1;
      end
      default: begin
      end
    endcase
    if (do_dispatch) begin
      res.switched   = 1'b1;
      res.old_thread = running;
      res.idle       = 1'b1;
      for (lvl = 0; lvl < DEF_NUM_LEVELS; lvl++) begin
        if (res.idle && occupied[lvl]) begin
          running          = dequeue(lvl);
          res.next_thread  = running;
          res.idle         = 1'b0;
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int want, int got);
    $display("%0t ns: decision mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      clear_shadow();
      awaited_decisions.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        decisions_seen++;
        if (awaited_decisions.size() == 0) begin
          report_mismatch("unexpected transaction", 0, 1);
        end else begin
          want = awaited_decisions.pop_front();
          if (want.switched) dispatches_seen++;
          if (want.idle) idles_seen++;
          if (rsp.switched !== want.switched)
            report_mismatch("switched", int'(want.switched), int'(rsp.switched));
          if (rsp.old_thread !== want.old_thread)
            report_mismatch("old_thread", int'(want.old_thread), int'(rsp.old_thread));
          if (rsp.next_thread !== want.next_thread)
            report_mismatch("next_thread", int'(want.next_thread), int'(rsp.next_thread));
          if (rsp.idle !== want.idle)
            report_mismatch("idle", int'(want.idle), int'(rsp.idle));
        end
      end
      if (req_valid && req_ready) begin
        awaited_decisions.push_back(predict_dispatch(req));
      end
    end
    outstanding = awaited_decisions.size();
  end

endmodule

/* tb/multilevel_feedback_scheduler_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multilevel feedback scheduler testbench
// Drives directed and random scheduler events through the scheduler under
// several handshake idling mixes; a checker beside it predicts every decision.
// ----------------------------------------------------------------------------

module multilevel_feedback_scheduler_tb;
  import mfs_pkg::*;

  // Event codes that the scheduler does not define; each must yield an empty
  // decision and leave the queues alone.
  localparam logic [REQ_TYPE_W-1:0] EV_RSVD5 = 3'd5;
  localparam logic [REQ_TYPE_W-1:0] EV_RSVD6 = 3'd6;
  localparam logic [REQ_TYPE_W-1:0] EV_RSVD7 = 3'd7;

  localparam int RANDOM_PER_PHASE = 112;
  localparam int NUM_PHASES       = 4;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  int mismatches;
  int outstanding;
  int decisions_seen;
  int dispatches_seen;
  int idles_seen;

  // Percentages of cycles in which the sender holds back and the receiver
  // refuses a decision transaction; changed from phase to phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Threads that have had a new event. Unblock and timer events are only
  // issued for these, since the remembered level of any other thread has
  // never been written.
  logic [DEF_MAX_THREADS-1:0] born = '0;
  int events_sent  = 0;
  int drains_taken = 0;

  always #6 clk = ~clk;

  multilevel_feedback_scheduler dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  mfs_sched_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_ready       (req_ready),
    .req             (req),
    .rsp_valid       (rsp_valid),
    .rsp_ready       (rsp_ready),
    .rsp             (rsp),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .decisions_seen  (decisions_seen),
    .dispatches_seen (dispatches_seen),
    .idles_seen      (idles_seen)
  );

  // The receiver decides afresh at every falling edge whether it will take a
  // decision at the next rising edge.
  always @(negedge clk) begin
    rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Presents one event and holds it until the scheduler takes the
  // transaction. Idle cycles before it carry random, invalid payloads.
  task automatic send_event(input logic [REQ_TYPE_W-1:0] kind, input logic [TID_W-1:0] tid);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      req_valid          <= 1'b0;
      req.req_type       <= REQ_TYPE_W'($urandom_range(7));
      req.thread_id      <= TID_W'($urandom_range(DEF_MAX_THREADS - 1));
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req       <= '{req_type: kind, thread_id: tid};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (kind == EV_NEW) born[tid] = 1'b1;
    events_sent++;
  endtask

  // Lowers valid and holds off until every predicted decision has arrived.
  task automatic drain_decisions();
    @(negedge clk);
    req_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    drains_taken++;
  endtask

  function automatic logic [TID_W-1:0] pick_known_thread();
    logic [TID_W-1:0] tid;
    do begin
      tid = TID_W'($urandom_range(DEF_MAX_THREADS - 1));
    end while (!born[tid]);
    return tid;
  endfunction

  // The mix keeps pushes and dispatches roughly balanced, so the queues
  // fill and empty again and idle dispatches keep occurring.
  task automatic send_random_event();
    int unsigned            roll;
    logic [TID_W-1:0]       tid;
    logic [REQ_TYPE_W-1:0]  rsvd;
    roll = $urandom_range(99);
    tid  = TID_W'($urandom_range(DEF_MAX_THREADS - 1));
    rsvd = REQ_TYPE_W'($urandom_range(int'(EV_RSVD7), int'(EV_RSVD5)));
    if (roll < 15) begin
      send_event(EV_NEW, tid);
    end else if (roll < 35) begin
      send_event(EV_BLOCK, tid);
    end else if (roll < 50) begin
      send_event(EV_END, tid);
    end else if (roll < 65) begin
      send_event(EV_UNBLOCK, pick_known_thread());
    end else if (roll < 95) begin
      send_event(EV_TIMER, pick_known_thread());
    end else begin
      send_event(rsvd, tid);
    end
  endtask

  initial begin
    // Synchronous reset, released at a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, with no idling on either side.
    // Dispatches with every queue empty, from the reset running thread.
    send_event(EV_BLOCK, 4'd0);
    send_event(EV_END, 4'd15);
    // Threads at both ends of the range and a middle thread enter level 0, the middle one twice.
    send_event(EV_NEW, 4'd0);
    send_event(EV_NEW, 4'd15);
    send_event(EV_NEW, 4'd5);
    send_event(EV_NEW, 4'd5);
    // Timer expiries demote a thread until it saturates at the lowest level.
    send_event(EV_TIMER, 4'd0);
    repeat (5) send_event(EV_TIMER, 4'd15);
    // Undefined event codes must be ignored.
    send_event(EV_RSVD5, 4'd15);
    send_event(EV_RSVD6, 4'd10);
    send_event(EV_RSVD7, 4'd0);
    // Unblocks put threads back at their remembered levels.
    send_event(EV_UNBLOCK, 4'd15);
    send_event(EV_UNBLOCK, 4'd5);
    send_event(EV_UNBLOCK, 4'd0);
    // Blocks and ends dispatch, down to an empty scheduler.
    send_event(EV_BLOCK, 4'd10);
    send_event(EV_END, 4'd3);
    send_event(EV_BLOCK, 4'd12);
    send_event(EV_END, 4'd9);
    send_event(EV_END, 4'd6);
    send_event(EV_BLOCK, 4'd4);
    drain_decisions();

    // Random part over four idling mixes. Each phase ends with the sender
    // holding off until every decision has come back.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 55;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 55;
        end
        default: begin
          send_idle_pct  = 20;
          recv_stall_pct = 20;
        end
      endcase
      repeat (RANDOM_PER_PHASE) send_random_event();
      drain_decisions();
    end

    // Let any stray transaction show itself before the verdict.
    recv_stall_pct = 0;
    repeat (16) @(negedge clk);

    $display("Sent %0d scheduler events over four idling mixes, draining %0d times.",
             events_sent, drains_taken);
    $display("Checked %0d decisions: %0d dispatches, %0d of them with every queue empty.",
             decisions_seen, dispatches_seen, idles_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("multilevel_feedback_scheduler_tb: PASS");
    end else begin
      $display("multilevel_feedback_scheduler_tb: FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake; far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("Timed out with %0d decisions still awaited.", outstanding);
    $display("multilevel_feedback_scheduler_tb: FAIL");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/mfs_pkg.sv
rtl/mfs_front.sv
rtl/mfs_cmd_queue.sv
rtl/mfs_back.sv
rtl/multilevel_feedback_scheduler.sv
tb/mfs_sched_checker.sv
tb/multilevel_feedback_scheduler_tb.sv
